FILE: rtl/cbts_pkg.sv
// ---------------------------------------------------------------------------
// cbts_pkg: shared types and constants for the CAN bit-timing search
// Field widths, search limits, status codes and the transfer structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbts_pkg;

    // Search limits
    localparam int NUM_PRESCALERS = 63;
    localparam int MIN_QUANTA     = 8;
    localparam int MAX_QUANTA     = 24;

    // Speed above this is bit/s, else kbit/s
    localparam int KBIT_LIMIT     = 5000;
    localparam int HZ_PER_MHZ     = 1000000;
    localparam int HZ_PER_KHZ     = 1000;

    // Field widths
    localparam int SPEED_W = 20;
    localparam int OSC_W   = 6;
    localparam int SJW_W   = 4;
    localparam int NUM_W   = 26;   // oscillator in Hz
    localparam int BASE_W  = 24;   // twice the bit rate
    localparam int DEN_W   = 30;   // base times (prescaler + 1)
    localparam int PRE_W   = 6;
    localparam int Q_W     = 5;
    localparam int SJWC_W  = 3;    // clamped jump width, 1..4
    localparam int PROD_W  = NUM_W + PRE_W + 1;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_PH2_LONG = 2'd2,
        ST_PH2_SJW  = 2'd3
    } cbts_status_t;

    typedef struct packed {
        logic [SPEED_W-1:0] bus_speed;
        logic [OSC_W-1:0]   osc_mhz;
        logic [SJW_W-1:0]   jump_width;
    } cbts_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [PRE_W-1:0] prescaler;
        logic [Q_W-1:0]   quanta_per_bit;
        logic [7:0]       cnf1_byte;
        logic [7:0]       cnf2_byte;
        logic [7:0]       cnf3_byte;
    } cbts_out_t;

    // Item travelling down the cell chain
    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [BASE_W-1:0] base;
        logic [DEN_W-1:0]  den;
        logic [PRE_W-1:0]  pre;
        logic [SJWC_W-1:0] sjw;
        logic              found;
        logic [NUM_W-1:0]  best_r;
        logic [PRE_W-1:0]  best_p;
        logic [Q_W-1:0]    best_q;
    } cbts_item_t;

endpackage

`default_nettype wire

FILE: rtl/cbts_cell.sv
// ---------------------------------------------------------------------------
// cbts_cell: one prescaler candidate of the search chain
// Divides the oscillator count by the candidate divisor, keeps the better
// candidate and passes the item on to the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbts_cell
    import cbts_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       adv,
    input  wire logic       in_valid,
    input  cbts_item_t      in_item,
    output logic            out_valid,
    output cbts_item_t      out_item
);

    logic              valid_reg;
    cbts_item_t        item_reg, item_next;
    logic [35:0]       rem, dsh;
    logic [Q_W-1:0]    quo;
    logic              ovf, qual, better;
    logic [PRE_W:0]    pp1, best_pp1;
    logic [PROD_W-1:0] lhs, rhs;

    // Short quotient by restoring division, five steps
    always_comb begin
        ovf = ({10'd0, in_item.num} >= ({6'd0, in_item.den} << 5));
        rem = {10'd0, in_item.num};
        quo = '0;
        for (int k = Q_W - 1; k >= 0; k--) begin
            dsh = {6'd0, in_item.den} << k;
            if (rem >= dsh) begin
                rem    = rem - dsh;
                quo[k] = 1'b1;
            end
        end
    end

    // Fractions share the base, so compare r1*(p2+1) against r2*(p1+1)
    assign pp1      = {1'b0, in_item.pre} + 1'b1;
    assign best_pp1 = {1'b0, in_item.best_p} + 1'b1;
    assign lhs      = rem[NUM_W-1:0] * best_pp1;
    assign rhs      = in_item.best_r * pp1;

    assign qual   = (in_item.den != '0) && !ovf
                 && (quo >= Q_W'(MIN_QUANTA)) && (quo <= Q_W'(MAX_QUANTA));
    assign better = !in_item.found || (lhs < rhs);

    always_comb begin
        item_next     = in_item;
        item_next.den = in_item.den + {{(DEN_W-BASE_W){1'b0}}, in_item.base};
        item_next.pre = in_item.pre + 1'b1;
        if (qual && better) begin
            item_next.found  = 1'b1;
            item_next.best_r = rem[NUM_W-1:0];
            item_next.best_p = in_item.pre;
            item_next.best_q = quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

FILE: rtl/cbts_finish.sv
// ---------------------------------------------------------------------------
// cbts_finish: segment split and configuration byte packing
// Turns the winning candidate into status and the three timing bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbts_finish
    import cbts_pkg::*;
(
    input  cbts_item_t item,
    output cbts_out_t  res
);

    logic [7:0]     x7;
    logic [15:0]    xs;
    logic [Q_W-1:0] sp, prop, ph1, ph2, sp_m1, ph1_m1, prop_m1, ph2_m1;
    logic [1:0]     sjw_m1;

    // floor(7q/10) via reciprocal, exact for 7q below 1024
    assign x7      = 8'(item.best_q) * 8'd7;
    assign xs      = 16'(x7) * 16'd205;
    assign sp      = Q_W'(xs >> 11);
    assign sp_m1   = sp - 1'b1;
    assign prop    = sp_m1 >> 1;
    assign ph1     = sp - prop - 1'b1;
    assign ph2     = item.best_q - sp;
    assign ph1_m1  = ph1 - 1'b1;
    assign prop_m1 = prop - 1'b1;
    assign ph2_m1  = ph2 - 1'b1;
    assign sjw_m1  = 2'(item.sjw - 1'b1);

    always_comb begin
        res = '0;
        if (!item.found) begin
            res.status = ST_NO_FIT;
        end else begin
            res.prescaler      = item.best_p;
            res.quanta_per_bit = item.best_q;
            if ((prop + ph1) < ph2) begin
                res.status = ST_PH2_LONG;
            end else if (ph2 <= Q_W'(item.sjw)) begin
                res.status = ST_PH2_SJW;
            end else begin
                res.status    = ST_OK;
                res.cnf1_byte = {sjw_m1, item.best_p};
                res.cnf2_byte = {2'b10, ph1_m1[2:0], prop_m1[2:0]};
                res.cnf3_byte = {5'b10000, ph2_m1[2:0]};
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/can_bit_timing_search_unit.sv
// ---------------------------------------------------------------------------
// can_bit_timing_search_unit: CAN bit-timing search, top level
// Input register, a chain of prescaler cells and an output register.
//
//   channel | direction | payload   | handshake
//   s_      | in        | cbts_in_t  | s_valid / s_ready
//   m_      | out       | cbts_out_t | m_valid / m_ready
//
// The chain holds one input stage, one cell per prescaler candidate
// (NUM_PRESCALERS cells) and one output register. One transfer per cycle unless m_ready stalls.
// Reset clears all valid bits; no clearing pass.
// The whole chain advances only when the output register is empty or taken,
// so a stall on m_ready holds every stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module can_bit_timing_search_unit
    import cbts_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  cbts_in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output cbts_out_t m_data
);

    logic              adv;
    logic              v_chain [0:NUM_PRESCALERS];
    cbts_item_t        i_chain [0:NUM_PRESCALERS];
    logic              in_valid_reg;
    cbts_item_t        in_item_reg, in_item_next;
    logic [BASE_W-1:0] rate;
    logic              m_valid_reg;
    cbts_out_t         m_data_reg, fin;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Input stage: Hz, bit rate and clamped jump width
    always_comb begin
        in_item_next = '0;
        in_item_next.num = NUM_W'(s_data.osc_mhz * 26'(HZ_PER_MHZ));
        if (s_data.bus_speed > SPEED_W'(KBIT_LIMIT)) begin
            rate = BASE_W'(s_data.bus_speed);
        end else begin
            rate = BASE_W'(s_data.bus_speed * 24'(HZ_PER_KHZ));
        end
        in_item_next.base = rate << 1;
        in_item_next.den  = {{(DEN_W-BASE_W){1'b0}}, in_item_next.base};
        if (s_data.jump_width == '0) begin
            in_item_next.sjw = SJWC_W'(1);
        end else if (s_data.jump_width > SJW_W'(4)) begin
            in_item_next.sjw = SJWC_W'(4);
        end else begin
            in_item_next.sjw = s_data.jump_width[SJWC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_item_reg <= in_item_next;
        end
    end

    assign v_chain[0] = in_valid_reg;
    assign i_chain[0] = in_item_reg;

    // One cell per prescaler candidate
    for (genvar g = 0; g < NUM_PRESCALERS; g++) begin : g_cell
        cbts_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (v_chain[g]),
            .in_item   (i_chain[g]),
            .out_valid (v_chain[g+1]),
            .out_item  (i_chain[g+1])
        );
    end

    cbts_finish u_finish (
        .item (i_chain[NUM_PRESCALERS]),
        .res  (fin)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v_chain[NUM_PRESCALERS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= fin;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: rtl/cbts_checker.sv
// ---------------------------------------------------------------------------
// cbts_checker: port-level checks for the bit-timing search
// Watches the result channel and the reset behavior.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbts_checker
    import cbts_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire cbts_out_t m_data
);

    // Held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the output
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Failure reports all zero
    a_nofit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_NO_FIT |->
        m_data.prescaler == '0 && m_data.quanta_per_bit == '0 &&
        m_data.cnf1_byte == '0 && m_data.cnf2_byte == '0 && m_data.cnf3_byte == '0)
        else $error("failure with nonzero fields");

    // A chosen candidate lies in the quanta window
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_NO_FIT |->
        m_data.quanta_per_bit >= Q_W'(MIN_QUANTA) &&
        m_data.quanta_per_bit <= Q_W'(MAX_QUANTA))
        else $error("quanta out of window");

    // Good result carries the fixed bits
    a_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_OK |->
        m_data.cnf2_byte[7] && m_data.cnf3_byte[7])
        else $error("timing bytes lack fixed bits");

endmodule

bind can_bit_timing_search_unit cbts_checker u_cbts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

FILE: sim/can_bit_timing_search_unit_test.sv
// ---------------------------------------------------------------------------
// can_bit_timing_search_unit_test: self-checking bench for the bit-timing search
// Drives requests through the valid/ready input, predicts every result
// with an independent search, and compares each field of each transfer
// in order. A directed table comes first, then random requests under
// several idling phases and a long receiver hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module can_bit_timing_search_unit_test;
    import cbts_pkg::*;

    localparam int LATENCY     = 65;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 650;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    cbts_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    cbts_out_t m_data;

    can_bit_timing_search_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Directed row: request, and optionally a typed-in expected result
    typedef struct {
        cbts_in_t  req;
        bit        fixed;
        cbts_out_t res;
    } timing_row_t;

    cbts_out_t timing_queue[$];
    int        mismatches;
    int        cycles;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_recv;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Bit-timing search from first principles
    function automatic cbts_out_t predict_timing(cbts_in_t req);
        cbts_out_t    res;
        logic [63:0]  rate, osc_hz, den, quo, rem, br, bd;
        logic [4:0]   bq;
        logic [5:0]   bp;
        logic [63:0]  sp, prop, ph1, ph2;
        logic [2:0]   sjw;
        bit           found;
        res   = '0;
        found = 0;
        br = 0; bd = 1; bq = 0; bp = 0;
        sjw    = (req.jump_width == 0) ? 3'd1 :
                 (req.jump_width > 4) ? 3'd4 : req.jump_width[2:0];
        rate   = (req.bus_speed > KBIT_LIMIT) ? 64'(req.bus_speed)
                                              : 64'(req.bus_speed) * HZ_PER_KHZ;
        osc_hz = 64'(req.osc_mhz) * HZ_PER_MHZ;
        if (rate != 0) begin
            for (int p = 0; p < NUM_PRESCALERS; p++) begin
                den = 2 * (p + 1) * rate;
                quo = osc_hz / den;
                rem = osc_hz % den;
                if (quo >= MIN_QUANTA && quo <= MAX_QUANTA &&
                    (!found || rem * bd < br * den)) begin
                    found = 1; br = rem; bd = den; bq = quo[4:0]; bp = 6'(p);
                end
            end
        end
        if (!found) begin
            res.status = ST_NO_FIT;
            return res;
        end
        res.prescaler      = bp;
        res.quanta_per_bit = bq;
        sp   = (7 * bq) / 10;
        prop = (sp - 1) / 2;
        ph1  = sp - prop - 1;
        ph2  = bq - sp;
        if (prop + ph1 < ph2) res.status = ST_PH2_LONG;
        else if (ph2 <= sjw) res.status = ST_PH2_SJW;
        else begin
            res.status    = ST_OK;
            res.cnf1_byte = {2'(sjw - 1), bp};
            res.cnf2_byte = {2'b10, 3'(ph1 - 1), 3'(prop - 1)};
            res.cnf3_byte = {5'b10000, 3'(ph2 - 1)};
        end
        return res;
    endfunction

    function automatic cbts_in_t make_req(int spd, int osc, int sjw);
        cbts_in_t r;
        r.bus_speed  = spd[SPEED_W-1:0];
        r.osc_mhz    = osc[OSC_W-1:0];
        r.jump_width = sjw[SJW_W-1:0];
        return r;
    endfunction

    // Mostly realistic rates, some raw noise over the full field range
    function automatic cbts_in_t random_req();
        int spd;
        case ($urandom_range(0, 5))
            0: spd = $urandom_range(1, 1000);
            1: spd = $urandom_range(5001, 1000000);
            2: spd = $urandom_range(0, 5000);
            3: spd = $urandom & 20'hFFFFF;
            default: spd = 10000 * $urandom_range(1, 100);
        endcase
        return make_req(spd, $urandom_range(0, 63), $urandom_range(0, 15));
    endfunction

    // Entered and left at a falling edge; valid drops only in idle cycles
    task automatic send_req(cbts_in_t req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        timing_queue.push_back(predict_timing(req));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (timing_queue.size() != 0) @(negedge aclk);
    endtask

    // Result checking at the rising edge
    always @(posedge aclk) begin
        cbts_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (timing_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: got %h", m_data);
            end else begin
                want = timing_queue.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d p=%0d q=%0d c1=%h c2=%h c3=%h",
                                 want.status, want.prescaler, want.quanta_per_bit,
                                 want.cnf1_byte, want.cnf2_byte, want.cnf3_byte,
                                 "  got st=%0d p=%0d q=%0d c1=%h c2=%h c3=%h",
                                 m_data.status, m_data.prescaler, m_data.quanta_per_bit,
                                 m_data.cnf1_byte, m_data.cnf2_byte, m_data.cnf3_byte);
                end
            end
        end
    end

    // Receiver stalls, changed at the falling edge
    always @(negedge aclk) begin
        m_ready <= !hold_recv && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        timing_row_t rows[$];
        timing_row_t row;
        cbts_out_t   none;
        mismatches     = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_recv      = 0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        aresetn        = 1'b0;
        none           = '0;
        none.status    = ST_NO_FIT;

        // Directed table: zero inputs and impossible rates have fixed answers
        rows.push_back('{make_req(0, 16, 1), 1, none});
        rows.push_back('{make_req(500, 0, 1), 1, none});
        rows.push_back('{make_req(1000000, 1, 15), 1, none});
        rows.push_back('{make_req(1, 1, 0), 0, none});
        rows.push_back('{make_req(20'hFFFFF, 63, 15), 0, none});
        rows.push_back('{make_req(500, 16, 0), 0, none});
        rows.push_back('{make_req(250, 16, 1), 0, none});
        rows.push_back('{make_req(125, 8, 2), 0, none});
        rows.push_back('{make_req(1000, 16, 3), 0, none});
        rows.push_back('{make_req(500000, 20, 4), 0, none});
        rows.push_back('{make_req(100, 40, 5), 0, none});
        rows.push_back('{make_req(5000, 40, 8), 0, none});
        rows.push_back('{make_req(5001, 40, 9), 0, none});
        rows.push_back('{make_req(10, 63, 1), 0, none});
        rows.push_back('{make_req(1, 40, 2), 0, none});
        rows.push_back('{make_req(1000, 24, 4), 0, none});
        rows.push_back('{make_req(1000, 8, 1), 0, none});
        rows.push_back('{make_req(1000, 9, 4), 0, none});
        rows.push_back('{make_req(83, 16, 4), 0, none});
        rows.push_back('{make_req(33, 25, 10), 0, none});
        rows.push_back('{make_req(20'h55555, 42, 6), 0, none});
        rows.push_back('{make_req(20'hAAAAA, 21, 7), 0, none});

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed requests, checked through the table or the predictor
        foreach (rows[i]) begin
            row = rows[i];
            send_req(row.req);
            if (row.fixed) timing_queue[timing_queue.size()-1] = row.res;
        end
        drain();

        // Random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 82 : 9) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 82 : 9) : 0;
            for (int n = 0; n < N_RANDOM / 5; n++) send_req(random_req());
            drain();
        end

        // Long receiver hold-off while requests keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_recv = 1;
                for (int c = 0; c < 300; c++) @(negedge aclk);
                hold_recv = 0;
            end
            for (int n = 0; n < N_RANDOM / 5; n++) send_req(random_req());
        join
        drain();

        for (int c = 0; c < 2 * LATENCY; c++) @(posedge aclk);
        if (mismatches == 0 && timing_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/cbts_pkg.sv
rtl/cbts_cell.sv
rtl/cbts_finish.sv
rtl/can_bit_timing_search_unit.sv
rtl/cbts_checker.sv
sim/can_bit_timing_search_unit_test.sv
